[rtl/carl_pkg.sv]
// Shared constants, character codes and the job record for the command link.
// No dependencies; every module of the block imports this package.
`default_nettype none
package carl_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int TIMER_BITS  = 16;
   localparam int CSR_BITS    = 16;

   // Decimal digits needed for the largest sample: floor(n * log10(2)) + 1.
   localparam int DIGITS       = ((SAMPLE_BITS * 1233) >> 12) + 1;
   localparam int DIG_IDX_BITS = $clog2(DIGITS);
   localparam int NDIG_BITS    = $clog2(DIGITS + 1);

   localparam int HEAD_LEN  = 5;
   localparam int HIDX_BITS = $clog2(HEAD_LEN);

   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_BITS-1:0] TIMEOUT_RESET = CSR_BITS'(3000);

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_R    = 8'h52;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_O    = 8'h4F;
   localparam logic [7:0] CH_K    = 8'h4B;
   localparam logic [7:0] CH_A    = 8'h41;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_C    = 8'h43;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;

   // 0xCCCD / 2^19 gives an exact divide by ten for values below 81920.
   localparam logic [15:0] RECIP10 = 16'hCCCD;
   localparam int RECIP10_SHIFT = 19;

   typedef struct packed {
      logic                   has_echo;
      logic [7:0]             echo;
      logic                   has_pkt;
      logic [SAMPLE_BITS-1:0] sample;
   } job_type;

   function automatic logic [7:0] head_char(input logic [HIDX_BITS-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         HIDX_BITS'(0): ch = CH_BANG;
         HIDX_BITS'(1): ch = CH_A;
         HIDX_BITS'(2): ch = CH_D;
         HIDX_BITS'(3): ch = CH_C;
         default:       ch = CH_EQ;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

[rtl/carl_front.sv]
// Front end of the command link: frame parser, link state and resend timer.
// Classifies each transaction into a job record; depends on carl_pkg.
`default_nettype none
module carl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [carl_pkg::CSR_BITS-1:0] csr_wr_data,
   input  wire logic                          accept,
   input  wire logic                          req_type,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic [carl_pkg::SAMPLE_BITS-1:0] req_adc_sample,
   output carl_pkg::job_type                  job,
   output logic                               job_valid
);
   import carl_pkg::*;

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_CMD1  = 3'd1;
   localparam logic [2:0] PH_RST2  = 3'd2;
   localparam logic [2:0] PH_RST3  = 3'd3;
   localparam logic [2:0] PH_OK2   = 3'd4;
   localparam logic [2:0] PH_END   = 3'd5;

   localparam logic [1:0] PC_NONE = 2'd0;
   localparam logic [1:0] PC_RST  = 2'd1;
   localparam logic [1:0] PC_OK   = 2'd2;

   localparam logic LK_IDLE = 1'b0;
   localparam logic LK_WAIT = 1'b1;

   logic [CSR_BITS-1:0]    timeout_ff, timeout_in;
   logic [2:0]             phase_ff, phase_in;
   logic [1:0]             pend_ff, pend_in;
   logic                   link_ff, link_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [TIMER_BITS-1:0]  ticks_ff, ticks_in;
   logic [1:0]             done;
   logic [2:0]             phase_dflt;
   logic [TIMER_BITS-1:0]  reload;

   assign reload     = TIMER_BITS'(timeout_ff);
   assign phase_dflt = (req_rx_byte == CH_BANG) ? PH_CMD1 : PH_START;
   assign timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;

   always_comb begin
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      link_in      = link_ff;
      sample_in    = sample_ff;
      ticks_in     = ticks_ff;
      done         = PC_NONE;
      job.has_echo = 1'b0;
      job.echo     = req_rx_byte;
      job.has_pkt  = 1'b0;
      if (accept) begin
         if (req_type == REQ_BYTE) begin
            job.has_echo = 1'b1;
            unique case (phase_ff)
               PH_START: begin
                  if (req_rx_byte == CH_BANG) phase_in = PH_CMD1;
               end
               PH_CMD1: begin
                  if (req_rx_byte == CH_R) begin
                     pend_in  = PC_RST;
                     phase_in = PH_RST2;
                  end else if (req_rx_byte == CH_O) begin
                     pend_in  = PC_OK;
                     phase_in = PH_OK2;
                  end else begin
                     phase_in = phase_dflt;
                  end
               end
               PH_RST2: phase_in = (req_rx_byte == CH_S) ? PH_RST3 : phase_dflt;
               PH_RST3: phase_in = (req_rx_byte == CH_T) ? PH_END : phase_dflt;
               PH_OK2:  phase_in = (req_rx_byte == CH_K) ? PH_END : phase_dflt;
               PH_END: begin
                  if (req_rx_byte == CH_HASH) begin
                     done     = pend_ff;
                     pend_in  = PC_NONE;
                     phase_in = PH_START;
                  end else begin
                     phase_in = phase_dflt;
                  end
               end
               default: phase_in = PH_START;
            endcase
            if (done == PC_RST) begin
               sample_in   = req_adc_sample;
               job.has_pkt = 1'b1;
               ticks_in    = reload;
               link_in     = LK_WAIT;
            end else if (done == PC_OK && link_ff == LK_WAIT) begin
               link_in = LK_IDLE;
            end
         end else if (link_ff == LK_WAIT) begin
            // A timer already at zero counts as expired on the next tick.
            if (ticks_ff == '0 || ticks_ff == TIMER_BITS'(1)) begin
               job.has_pkt = 1'b1;
               ticks_in    = reload;
            end else begin
               ticks_in = ticks_ff - 1'b1;
            end
         end
      end
      job.sample = sample_in;
      job_valid  = job.has_echo | job.has_pkt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= PH_START;
         pend_ff    <= PC_NONE;
         link_ff    <= LK_IDLE;
         sample_ff  <= '0;
         ticks_ff   <= '0;
      end else begin
         timeout_ff <= timeout_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         link_ff    <= link_in;
         sample_ff  <= sample_in;
         ticks_ff   <= ticks_in;
      end
   end

   // Every packet leaves the link waiting for an acknowledge.
   a_pkt_waits: assert property (@(posedge clock) disable iff (reset)
      job_valid && job.has_pkt |=> link_ff == LK_WAIT)
      else $error("link not waiting after a packet was issued");

endmodule
`default_nettype wire

[rtl/carl_queue.sv]
// Short job queue between the front end and the transmit sequencer.
// Holds carl_pkg::job_type records; depends on carl_pkg.
`default_nettype none
module carl_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire carl_pkg::job_type wr_job,
   output logic                   full,
   input  wire logic              pop,
   output carl_pkg::job_type      rd_job,
   output logic                   empty
);
   import carl_pkg::*;

   job_type               slots_ff [QUEUE_DEPTH];
   logic [QIDX_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QIDX_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_job  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule
`default_nettype wire

[rtl/carl_back.sv]
// Transmit sequencer: turns one job into echo and packet bytes, one per cycle
// while pop is high. Converts the sample to decimal one digit per cycle; depends on carl_pkg.
`default_nettype none
module carl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire carl_pkg::job_type job,
   input  wire logic              job_avail,
   output logic                   job_take,
   input  wire logic              pop,
   output logic                   empty,
   output logic [7:0]             tx_byte,
   output logic                   tx_last
);
   import carl_pkg::*;

   localparam logic [2:0] BK_IDLE  = 3'd0;
   localparam logic [2:0] BK_ECHO  = 3'd1;
   localparam logic [2:0] BK_HEAD  = 3'd2;
   localparam logic [2:0] BK_DIGIT = 3'd3;
   localparam logic [2:0] BK_HASH  = 3'd4;
   localparam logic [2:0] BK_CR    = 3'd5;
   localparam logic [2:0] BK_LF    = 3'd6;

   localparam int PROD_BITS = SAMPLE_BITS + 16;

   logic [2:0]             state_ff, state_in;
   logic [HIDX_BITS-1:0]   idx_ff, idx_in;
   logic [NDIG_BITS-1:0]   cnt_ff, cnt_in;
   logic [7:0]             echo_ff, echo_in;
   logic                   has_pkt_ff, has_pkt_in;
   logic [SAMPLE_BITS-1:0] conv_ff, conv_in;
   logic                   busy_ff, busy_in;
   logic [NDIG_BITS-1:0]   ndig_ff, ndig_in;
   logic [3:0]             digits_ff [DIGITS];
   logic                   dig_we;
   logic [PROD_BITS-1:0]   prod;
   logic [SAMPLE_BITS-1:0] quot;
   logic [SAMPLE_BITS-1:0] rem_full;
   logic [3:0]             rem;
   logic [DIG_IDX_BITS-1:0] rd_idx;
   logic                   take;

   assign empty    = (state_ff == BK_IDLE);
   assign take     = pop & ~empty;
   assign tx_last  = (state_ff == BK_LF) || (state_ff == BK_ECHO && !has_pkt_ff);
   assign job_take = job_avail && (empty || (take && tx_last));

   // Divide by ten through the reciprocal; the remainder is the next digit.
   assign prod     = {16'd0, conv_ff} * {{SAMPLE_BITS{1'b0}}, RECIP10};
   assign quot     = SAMPLE_BITS'(prod >> RECIP10_SHIFT);
   assign rem_full = conv_ff - ((quot << 3) + (quot << 1));
   assign rem      = rem_full[3:0];
   assign rd_idx   = DIG_IDX_BITS'(ndig_ff - cnt_ff - 1'b1);

   always_comb begin
      unique case (state_ff)
         BK_ECHO:  tx_byte = echo_ff;
         BK_HEAD:  tx_byte = head_char(idx_ff);
         BK_DIGIT: tx_byte = CH_ZERO + {4'd0, digits_ff[rd_idx]};
         BK_HASH:  tx_byte = CH_HASH;
         BK_CR:    tx_byte = CH_CR;
         BK_LF:    tx_byte = CH_LF;
         default:  tx_byte = 8'd0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      echo_in    = echo_ff;
      has_pkt_in = has_pkt_ff;
      conv_in    = conv_ff;
      busy_in    = busy_ff;
      ndig_in    = ndig_ff;
      dig_we     = 1'b0;
      if (job_take) begin
         state_in   = job.has_echo ? BK_ECHO : BK_HEAD;
         idx_in     = '0;
         cnt_in     = '0;
         echo_in    = job.echo;
         has_pkt_in = job.has_pkt;
         conv_in    = job.sample;
         busy_in    = job.has_pkt;
         ndig_in    = '0;
      end else begin
         if (take) begin
            unique case (state_ff)
               BK_ECHO: begin
                  state_in = has_pkt_ff ? BK_HEAD : BK_IDLE;
                  idx_in   = '0;
               end
               BK_HEAD: begin
                  if (idx_ff == HIDX_BITS'(HEAD_LEN - 1)) begin
                     state_in = BK_DIGIT;
                     cnt_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               BK_DIGIT: begin
                  if (NDIG_BITS'(cnt_ff + 1'b1) == ndig_ff) begin
                     state_in = BK_HASH;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               BK_HASH: state_in = BK_CR;
               BK_CR:   state_in = BK_LF;
               default: state_in = BK_IDLE;
            endcase
         end
         // The header takes at least as many cycles as the conversion needs.
         if (busy_ff) begin
            dig_we  = 1'b1;
            conv_in = quot;
            ndig_in = ndig_ff + 1'b1;
            busy_in = (quot != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dig_we) begin
         digits_ff[ndig_ff[DIG_IDX_BITS-1:0]] <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         has_pkt_ff <= 1'b0;
         busy_ff    <= 1'b0;
         ndig_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         has_pkt_ff <= has_pkt_in;
         busy_ff    <= busy_in;
         ndig_ff    <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_ff <= echo_in;
      conv_ff <= conv_in;
   end

   a_digits_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DIGIT |-> !busy_ff && ndig_ff != '0)
      else $error("digit sent before decimal conversion finished");

   a_ndig_range: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= NDIG_BITS'(DIGITS))
      else $error("digit count exceeds the digit store");

endmodule
`default_nettype wire

[rtl/command_ack_retransmit_link_core.sv]
// Command / acknowledge / retransmit link.
//
// Input queue port: a transaction is taken when push is high and full is low.
// req_type 0 carries a received byte in req_rx_byte, req_type 1 is one timer
// tick; req_adc_sample is latched when an !RST# frame completes. Each byte is
// echoed, and an RST or a timer expiry sends !ADC=<decimal>#\r\n.
// Result queue port: while empty is low, rsp_tx_byte/rsp_tx_last show the
// oldest byte; it is taken when pop is high. rsp_tx_last marks the final
// byte produced by one input transaction. Ticks with nothing to send produce
// no bytes.
// The front end takes one transaction per cycle while full is low, into a
// four-job queue. The transmit sequencer sends one byte per cycle while
// pop is high: one byte for an echo, 8 plus the digit count for a packet,
// 13 at most for one transaction. Throughput is set by that sequencer; an
// accepted job passes the queue slot, then the sequencer state register.
// When pop stays low, bytes hold and full rises once the job queue fills.
// Synchronous reset clears the parser, link state, timer and both queues and
// loads the timeout register with 3000. csr_wr_en writes the timeout.
`default_nettype none
module command_ack_retransmit_link_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic                             req_type,
   input  wire logic [7:0]                       req_rx_byte,
   input  wire logic [carl_pkg::SAMPLE_BITS-1:0] req_adc_sample,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [7:0]                            rsp_tx_byte,
   output logic                                  rsp_tx_last,
   input  wire logic                             csr_wr_en,
   input  wire logic [carl_pkg::CSR_BITS-1:0]    csr_wr_data
);
   import carl_pkg::*;

   job_type fr_job, q_job;
   logic    fr_valid, accept, q_empty, q_take;

   assign accept = push & ~full;

   carl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .accept         (accept),
      .req_type       (req_type),
      .req_rx_byte    (req_rx_byte),
      .req_adc_sample (req_adc_sample),
      .job            (fr_job),
      .job_valid      (fr_valid)
   );

   carl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (fr_valid),
      .wr_job (fr_job),
      .full   (full),
      .pop    (q_take),
      .rd_job (q_job),
      .empty  (q_empty)
   );

   carl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (q_job),
      .job_avail (~q_empty),
      .job_take  (q_take),
      .pop       (pop),
      .empty     (empty),
      .tx_byte   (rsp_tx_byte),
      .tx_last   (rsp_tx_last)
   );

endmodule
`default_nettype wire
